@@ rtl/ssi_pkg.sv @@
// ssi_pkg: shared types and constants of the sorted sequence intersection block
// used by ssi_walk and sorted_sequence_intersection_top; no dependencies
package ssi_pkg;

  localparam int DATA_W = 32;

  // bit positions in the tuser words
  localparam int IN_USER_SEL    = 0;
  localparam int OUT_USER_EMPTY = 0;
  localparam int OUT_USER_OVF   = 1;
  localparam int OUT_USER_W     = 2;

  typedef struct packed {
    logic start;
    logic cut;
  } walk_ctl_t;

  typedef struct packed {
    logic busy;
    logic finish;
  } walk_stat_t;

endpackage

@@ rtl/sorted_sequence_intersection_top.sv @@
// Sorted sequence intersection. Input beats are loaded one per cycle into two stores
// (one ram each); a beat with tlast closes its sequence, and the beat that closes the
// second open sequence starts a merge walk. The walk takes one pointer step per cycle,
// each step one read of both rams and one compare, and then one closing step; it is held
// longer only while the output is stalled. No input beat is taken during the walk.
// Output beats carry the common values in order, tlast on the final one, or one
// empty-flagged beat when nothing matched.
// depends on ssi_pkg, ssi_ram, ssi_walk
module sorted_sequence_intersection_top #(
  parameter int SEQ_DEPTH  = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [ssi_pkg::DATA_W-1:0]        s_tdata,   // value
  input  logic                              s_tlast,   // is_end
  input  logic [0:0]                        s_tuser,   // list_select
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [ssi_pkg::DATA_W-1:0]        m_tdata,   // common_value
  output logic                              m_tlast,   // last_of_run
  output logic [ssi_pkg::OUT_USER_W-1:0]    m_tuser    // is_empty, overflowed
);

  localparam int CNT_W  = $clog2(SEQ_DEPTH + 1);
  localparam int ADDR_W = $clog2(SEQ_DEPTH);

  logic [CNT_W-1:0]      count_a;
  logic [CNT_W-1:0]      count_b;
  logic                  done_a;
  logic                  done_b;
  logic                  cut;

  logic                  accept;
  logic                  sel;
  logic                  side_done;
  logic                  side_full;
  logic                  wr_a;
  logic                  wr_b;
  logic                  start;
  logic [VALUE_BITS-1:0] wr_data;
  logic [ADDR_W-1:0]     rd_addr_a;
  logic [ADDR_W-1:0]     rd_addr_b;
  logic [VALUE_BITS-1:0] rd_data_a;
  logic [VALUE_BITS-1:0] rd_data_b;

  ssi_pkg::walk_ctl_t    ctl;
  ssi_pkg::walk_stat_t   stat;

  assign s_tready  = !stat.busy;
  assign accept    = s_tvalid && s_tready;
  assign sel       = s_tuser[ssi_pkg::IN_USER_SEL];
  assign side_done = sel ? done_b : done_a;
  assign side_full = sel ? (count_b >= CNT_W'(SEQ_DEPTH)) : (count_a >= CNT_W'(SEQ_DEPTH));
  assign wr_a      = accept && !sel && !done_a && !s_tlast && !side_full;
  assign wr_b      = accept && sel && !done_b && !s_tlast && !side_full;
  assign start     = accept && s_tlast && !side_done && (sel ? done_a : done_b);
  assign wr_data   = VALUE_BITS'(s_tdata);

  assign ctl.start = start;
  assign ctl.cut   = cut;

  always_ff @(posedge clk) begin
    if (rst || stat.finish) begin
      count_a <= '0;
      count_b <= '0;
      done_a  <= 1'b0;
      done_b  <= 1'b0;
      cut     <= 1'b0;
    end else if (accept && !side_done) begin
      if (s_tlast) begin
        if (sel) begin
          done_b <= 1'b1;
        end else begin
          done_a <= 1'b1;
        end
      end else if (side_full) begin
        cut <= 1'b1;
      end else if (sel) begin
        count_b <= count_b + 1'b1;
      end else begin
        count_a <= count_a + 1'b1;
      end
    end
  end

  ssi_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (SEQ_DEPTH)
  ) u_store_a (
    .clk     (clk),
    .wr_en   (wr_a),
    .wr_addr (count_a[ADDR_W-1:0]),
    .wr_data (wr_data),
    .rd_addr (rd_addr_a),
    .rd_data (rd_data_a)
  );

  ssi_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (SEQ_DEPTH)
  ) u_store_b (
    .clk     (clk),
    .wr_en   (wr_b),
    .wr_addr (count_b[ADDR_W-1:0]),
    .wr_data (wr_data),
    .rd_addr (rd_addr_b),
    .rd_data (rd_data_b)
  );

  ssi_walk #(
    .SEQ_DEPTH  (SEQ_DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_walk (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .count_a   (count_a),
    .count_b   (count_b),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b),
    .stat      (stat),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_last  (m_tlast),
    .out_empty (m_tuser[ssi_pkg::OUT_USER_EMPTY]),
    .out_ovf   (m_tuser[ssi_pkg::OUT_USER_OVF])
  );

endmodule

@@ rtl/ssi_ram.sv @@
// ssi_ram: generic simple dual-port ram, one write port and one registered read port
// no dependencies
module ssi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/ssi_walk.sv @@
// ssi_walk: two-pointer merge walk over both stores with a held match and an output register
// depends on ssi_pkg; reads the stores held in sorted_sequence_intersection_top
module ssi_walk #(
  parameter int SEQ_DEPTH  = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  ssi_pkg::walk_ctl_t                 ctl,
  input  logic [$clog2(SEQ_DEPTH+1)-1:0]     count_a,
  input  logic [$clog2(SEQ_DEPTH+1)-1:0]     count_b,
  output logic [$clog2(SEQ_DEPTH)-1:0]       rd_addr_a,
  output logic [$clog2(SEQ_DEPTH)-1:0]       rd_addr_b,
  input  logic [VALUE_BITS-1:0]              rd_data_a,
  input  logic [VALUE_BITS-1:0]              rd_data_b,
  output ssi_pkg::walk_stat_t                stat,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [ssi_pkg::DATA_W-1:0]         out_data,
  output logic                               out_last,
  output logic                               out_empty,
  output logic                               out_ovf
);

  localparam int CNT_W  = $clog2(SEQ_DEPTH + 1);
  localparam int ADDR_W = $clog2(SEQ_DEPTH);

  typedef enum logic {IDLE, WALK} state_t;

  state_t                     state;
  logic [CNT_W-1:0]           i;
  logic [CNT_W-1:0]           j;
  logic [CNT_W-1:0]           i_next;
  logic [CNT_W-1:0]           j_next;
  logic [ssi_pkg::DATA_W-1:0] held;
  logic                       have_held;

  logic in_range;
  logic slot_free;
  logic take;
  logic push;
  logic push_last;
  logic finish;

  always_comb begin
    in_range  = (i < count_a) && (j < count_b);
    slot_free = !out_valid || out_ready;
    i_next    = i;
    j_next    = j;
    take      = 1'b0;
    push      = 1'b0;
    push_last = 1'b0;
    finish    = 1'b0;
    if (state == WALK) begin
      if (!in_range) begin
        if (slot_free) begin
          push      = 1'b1;
          push_last = 1'b1;
          finish    = 1'b1;
          i_next    = '0;
          j_next    = '0;
        end
      end else if (rd_data_a < rd_data_b) begin
        i_next = i + 1'b1;
      end else if (rd_data_a > rd_data_b) begin
        j_next = j + 1'b1;
      end else if (!have_held || slot_free) begin
        take   = 1'b1;
        push   = have_held;
        i_next = i + 1'b1;
        j_next = j + 1'b1;
      end
    end
  end

  assign rd_addr_a   = i_next[ADDR_W-1:0];
  assign rd_addr_b   = j_next[ADDR_W-1:0];
  assign stat.busy   = (state == WALK);
  assign stat.finish = finish;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      i         <= '0;
      j         <= '0;
      have_held <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      i <= i_next;
      j <= j_next;
      case (state)
        IDLE: begin
          if (ctl.start) begin
            state <= WALK;
          end
        end
        WALK: begin
          if (finish) begin
            state     <= IDLE;
            have_held <= 1'b0;
          end else if (take) begin
            have_held <= 1'b1;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held <= ssi_pkg::DATA_W'(rd_data_a);
    end
    if (push) begin
      out_data  <= (push_last && !have_held) ? '0 : held;
      out_last  <= push_last;
      out_empty <= push_last && !have_held;
      out_ovf   <= ctl.cut;
    end
  end

  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    state == WALK |-> (i <= count_a) && (j <= count_b))
    else $error("walk pointer past fill count");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_empty |-> out_last && (out_data == '0))
    else $error("empty beat not last or not zero");

  a_start_walk: assert property (@(posedge clk) disable iff (rst)
    state == IDLE && ctl.start |=> state == WALK)
    else $error("start did not begin walk");

  a_finish_idle: assert property (@(posedge clk) disable iff (rst)
    finish |=> state == IDLE && i == '0 && j == '0 && !have_held && out_valid && out_last)
    else $error("walk did not close cleanly");

endmodule
